// ===== src/pwm_ppfd_pkg.sv =====
// Shared types and constants for the PWM pulse-pair frame decoder.
package pwm_ppfd_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int IDX_W       = 9;
    localparam int COUNT_W     = 7;
    localparam int LOW_W       = 64;
    localparam int HIGH_W      = 2;
    localparam int PCT_SCALE   = 100;

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TIME      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE_PCT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_PULSES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_TARGET      = 3'd4;

    localparam logic [15:0] RST_SHORT_TIME      = 16'd400;
    localparam logic [15:0] RST_LONG_TIME       = 16'd800;
    localparam logic [6:0]  RST_TOLERANCE_PCT   = 7'd25;
    localparam logic [7:0]  RST_PREAMBLE_PULSES = 8'd0;
    localparam logic [6:0]  RST_BIT_TARGET      = 7'd66;

    typedef struct packed {
        logic [15:0] short_time;
        logic [15:0] long_time;
        logic [6:0]  tolerance_pct;
        logic [7:0]  preamble_pulses;
        logic [6:0]  bit_target;
    } cfg_t;

    typedef struct packed {
        logic matched;
        logic data_bit;
    } pair_t;

endpackage

// ===== src/pwm_ppfd_in_if.sv =====
// Input channel: one measured pulse duration per beat.
interface pwm_ppfd_in_if #(
    parameter int TIME_WIDTH = 16
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] pulse_time;
    logic                  last_pulse;

    modport source (output valid, output pulse_time, output last_pulse, input ready);
    modport sink   (input valid, input pulse_time, input last_pulse, output ready);
endinterface

// ===== src/pwm_ppfd_out_if.sv =====
// Output channel: one decoded frame result per beat.
interface pwm_ppfd_out_if;
    logic        valid;
    logic        ready;
    logic        frame_failed;
    logic [31:0] rolling_code;
    logic [27:0] serial_number;
    logic [3:0]  button_id;
    logic [1:0]  frame_status;
    logic [6:0]  bits_received;
    logic [63:0] raw_low_word;

    modport source (
        output valid, output frame_failed, output rolling_code, output serial_number,
        output button_id, output frame_status, output bits_received, output raw_low_word,
        input ready
    );
    modport sink (
        input valid, input frame_failed, input rolling_code, input serial_number,
        input button_id, input frame_status, input bits_received, input raw_low_word,
        output ready
    );
endinterface

// ===== src/pwm_ppfd_cfg.sv =====
// Configuration register file of the PWM pulse-pair frame decoder.
module pwm_ppfd_cfg
    import pwm_ppfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_TIME:      cfg_next.short_time      = cfg_data;
                REG_LONG_TIME:       cfg_next.long_time       = cfg_data;
                REG_TOLERANCE_PCT:   cfg_next.tolerance_pct   = cfg_data[6:0];
                REG_PREAMBLE_PULSES: cfg_next.preamble_pulses = cfg_data[7:0];
                REG_BIT_TARGET:      cfg_next.bit_target      = cfg_data[6:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_time      <= RST_SHORT_TIME;
            cfg_reg.long_time       <= RST_LONG_TIME;
            cfg_reg.tolerance_pct   <= RST_TOLERANCE_PCT;
            cfg_reg.preamble_pulses <= RST_PREAMBLE_PULSES;
            cfg_reg.bit_target      <= RST_BIT_TARGET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pwm_ppfd_decode.sv =====
// Pair classifier: matches a high/low duration pair against short and long times.
module pwm_ppfd_decode
    import pwm_ppfd_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic [TIME_WIDTH-1:0] hi_time,
    input  logic [TIME_WIDTH-1:0] lo_time,
    input  cfg_t                  cfg,
    output pair_t                 pair
);

    localparam int PW = TIME_WIDTH + 8;

    logic [TIME_WIDTH-1:0] short_nom;
    logic [TIME_WIDTH-1:0] long_nom;
    logic [PW-1:0]         short_win;
    logic [PW-1:0]         long_win;
    logic                  hi_short;
    logic                  hi_long;
    logic                  lo_short;
    logic                  lo_long;

    // |d - nom| < floor(win/100)  <=>  100*(|d - nom| + 1) <= win
    function automatic logic near_time(
        input logic [TIME_WIDTH-1:0] d,
        input logic [TIME_WIDTH-1:0] nom,
        input logic [PW-1:0]         win
    );
        logic [TIME_WIDTH-1:0] diff;
        logic [PW-1:0]         lhs;
        diff = (d > nom) ? (d - nom) : (nom - d);
        lhs  = (PW'(diff) + PW'(1)) * PW'(PCT_SCALE);
        return lhs <= win;
    endfunction

    assign short_nom = TIME_WIDTH'(cfg.short_time);
    assign long_nom  = TIME_WIDTH'(cfg.long_time);
    assign short_win = PW'(short_nom) * PW'(cfg.tolerance_pct);
    assign long_win  = PW'(long_nom) * PW'(cfg.tolerance_pct);

    assign hi_short = near_time(hi_time, short_nom, short_win);
    assign hi_long  = near_time(hi_time, long_nom, long_win);
    assign lo_short = near_time(lo_time, short_nom, short_win);
    assign lo_long  = near_time(lo_time, long_nom, long_win);

    always_comb
    begin
        pair.matched  = 1'b0;
        pair.data_bit = 1'b0;
        if (hi_short && lo_long)
        begin
            pair.matched = 1'b1;
        end
        else if (hi_long && lo_short)
        begin
            pair.matched  = 1'b1;
            pair.data_bit = 1'b1;
        end
    end

endmodule

// ===== src/pwm_pulse_pair_frame_decoder.sv =====
// Top level of the PWM pulse-pair frame decoder: input register, frame state, result register.
// The input register holds one beat; a last-pulse beat loads its result into the result register.
// Throughput: one pulse beat per cycle; only a last-pulse beat waits on a full result register.
// The decode path is one pass through the pair classifier between the two registers.
// Reset: configuration returns to its defaults, frame state clears, both registers empty.
module pwm_pulse_pair_frame_decoder
    import pwm_ppfd_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    pwm_ppfd_in_if.sink            in_ch,
    pwm_ppfd_out_if.source         out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    pair_t pair;

    logic                  pend_valid_reg;
    logic                  pend_last_reg;
    logic [TIME_WIDTH-1:0] pend_time_reg;

    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [TIME_WIDTH-1:0] held_reg;
    logic [TIME_WIDTH-1:0] held_next;
    logic [LOW_W-1:0]      low_reg;
    logic [LOW_W-1:0]      low_next;
    logic [HIGH_W-1:0]     high_reg;
    logic [HIGH_W-1:0]     high_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  stopped_reg;
    logic                  stopped_next;

    logic                  res_valid_reg;
    logic                  res_failed_reg;
    logic [LOW_W-1:0]      res_low_reg;
    logic [HIGH_W-1:0]     res_high_reg;
    logic [COUNT_W-1:0]    res_count_reg;

    logic                  fire;
    logic                  skipped;
    logic                  frame_ok;
    logic [IDX_W-1:0]      pre;

    pwm_ppfd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwm_ppfd_decode #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_decode (
        .hi_time (held_reg),
        .lo_time (pend_time_reg),
        .cfg     (cfg),
        .pair    (pair)
    );

    assign fire = pend_valid_reg && (!pend_last_reg || !res_valid_reg || out_ch.ready);
    assign in_ch.ready = !pend_valid_reg || fire;
    assign pre = IDX_W'(cfg.preamble_pulses);

    always_comb
    begin
        idx_next     = idx_reg;
        held_next    = held_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        skipped      = 1'b0;
        if (idx_reg < pre)
        begin
            idx_next = idx_reg + IDX_W'(1);
            skipped  = 1'b1;
        end
        else if ((idx_reg[0] ^ pre[0]) == 1'b0)
        begin
            held_next = pend_time_reg;
            idx_next  = pre + IDX_W'(1);
        end
        else
        begin
            idx_next = pre;
            if (!stopped_reg && (count_reg < cfg.bit_target))
            begin
                if (pair.matched)
                begin
                    low_next   = {low_reg[LOW_W-2:0], pair.data_bit};
                    high_next  = {high_reg[0], low_reg[LOW_W-1]};
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
        end
        frame_ok = !skipped && (count_next >= cfg.bit_target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            pend_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            pend_time_reg <= in_ch.pulse_time;
            pend_last_reg <= in_ch.last_pulse;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            held_reg    <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (pend_last_reg)
            begin
                idx_reg     <= '0;
                held_reg    <= '0;
                low_reg     <= '0;
                high_reg    <= '0;
                count_reg   <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                idx_reg     <= idx_next;
                held_reg    <= held_next;
                low_reg     <= low_next;
                high_reg    <= high_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire && pend_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && pend_last_reg)
        begin
            res_failed_reg <= !frame_ok;
            res_low_reg    <= frame_ok ? low_next : '0;
            res_high_reg   <= frame_ok ? high_next : '0;
            res_count_reg  <= count_next;
        end
    end

    assign out_ch.valid         = res_valid_reg;
    assign out_ch.frame_failed  = res_failed_reg;
    assign out_ch.rolling_code  = res_low_reg[31:0];
    assign out_ch.serial_number = res_low_reg[59:32];
    assign out_ch.button_id     = res_low_reg[63:60];
    assign out_ch.frame_status  = res_high_reg;
    assign out_ch.bits_received = res_count_reg;
    assign out_ch.raw_low_word  = res_low_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pend_last_reg |=> res_valid_reg)
        else $error("last pulse beat did not load the result register");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pend_last_reg |=> idx_reg == '0 && count_reg == '0 && !stopped_reg)
        else $error("frame state not cleared after last pulse");

    a_failed_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_failed_reg |-> res_low_reg == '0 && res_high_reg == '0)
        else $error("failed frame carries nonzero payload");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(256))
        else $error("pulse index out of range");

endmodule

// ===== test/pwm_pulse_pair_frame_decoder_test.sv =====
// Self-checking testbench for the PWM pulse-pair frame decoder: directed and random captures.
import pwm_ppfd_pkg::*;

typedef struct packed {
    logic        frame_failed;
    logic [31:0] rolling_code;
    logic [27:0] serial_number;
    logic [3:0]  button_id;
    logic [1:0]  frame_status;
    logic [6:0]  bits_received;
    logic [63:0] raw_low_word;
} frame_result_t;

class frame_scoreboard;
    logic [15:0]   short_time;
    logic [15:0]   long_time;
    logic [6:0]    tol_pct;
    logic [7:0]    preamble;
    logic [6:0]    bit_target;

    int unsigned   pulse_idx;
    logic [15:0]   held_high;
    logic [63:0]   shift_lo;
    logic [1:0]    shift_hi;
    logic [6:0]    nbits;
    bit            stopped;

    frame_result_t expected_frames[$];
    int            failures;
    int            results_seen;

    function new();
        short_time   = RST_SHORT_TIME;
        long_time    = RST_LONG_TIME;
        tol_pct      = RST_TOLERANCE_PCT;
        preamble     = RST_PREAMBLE_PULSES;
        bit_target   = RST_BIT_TARGET;
        failures     = 0;
        results_seen = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        pulse_idx = 0;
        held_high = '0;
        shift_lo  = '0;
        shift_hi  = '0;
        nbits     = '0;
        stopped   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SHORT_TIME:      short_time = data;
            REG_LONG_TIME:       long_time  = data;
            REG_TOLERANCE_PCT:   tol_pct    = data[6:0];
            REG_PREAMBLE_PULSES: preamble   = data[7:0];
            REG_BIT_TARGET:      bit_target = data[6:0];
            default: ;
        endcase
    endfunction

    // strict |d - T| < floor(T*tol/100), in 32-bit arithmetic
    function bit near_nominal(logic [15:0] d, logic [15:0] nominal);
        int unsigned n;
        int unsigned window;
        int unsigned diff;
        n      = 32'(nominal);
        window = n * tol_pct / PCT_SCALE;
        diff   = (d > nominal) ? 32'(d - nominal) : 32'(nominal - d);
        return diff < window;
    endfunction

    function void note_beat(logic [15:0] t, logic is_last);
        frame_result_t exp;
        bit            skipped;
        logic          data_bit;
        skipped = 1'b0;
        if (pulse_idx < preamble)
        begin
            pulse_idx++;
            skipped = 1'b1;
        end
        else if (((pulse_idx - preamble) & 1) == 0)
        begin
            held_high = t;
            pulse_idx = 32'(preamble) + 1;
        end
        else
        begin
            pulse_idx = 32'(preamble);
            if (!stopped && nbits < bit_target)
            begin
                if (near_nominal(held_high, short_time) && near_nominal(t, long_time))
                    data_bit = 1'b0;
                else if (near_nominal(held_high, long_time) && near_nominal(t, short_time))
                    data_bit = 1'b1;
                else
                    stopped = 1'b1;
                if (!stopped)
                begin
                    shift_hi = {shift_hi[0], shift_lo[63]};
                    shift_lo = {shift_lo[62:0], data_bit};
                    nbits    = nbits + 7'd1;
                end
            end
        end
        if (!is_last)
            return;
        exp = '0;
        exp.bits_received = nbits;
        if (!skipped && nbits >= bit_target)
        begin
            exp.rolling_code  = shift_lo[31:0];
            exp.serial_number = shift_lo[59:32];
            exp.button_id     = shift_lo[63:60];
            exp.frame_status  = shift_hi;
            exp.raw_low_word  = shift_lo;
        end
        else
            exp.frame_failed = 1'b1;
        expected_frames.push_back(exp);
        clear_frame();
    endfunction

    function void check_result(frame_result_t got);
        frame_result_t exp;
        string         bad;
        results_seen++;
        if (expected_frames.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected frame result beat: %h", got);
            return;
        end
        exp = expected_frames.pop_front();
        bad = "";
        if (got.frame_failed !== exp.frame_failed)   bad = {bad, " frame_failed"};
        if (got.rolling_code !== exp.rolling_code)   bad = {bad, " rolling_code"};
        if (got.serial_number !== exp.serial_number) bad = {bad, " serial_number"};
        if (got.button_id !== exp.button_id)         bad = {bad, " button_id"};
        if (got.frame_status !== exp.frame_status)   bad = {bad, " frame_status"};
        if (got.bits_received !== exp.bits_received) bad = {bad, " bits_received"};
        if (got.raw_low_word !== exp.raw_low_word)   bad = {bad, " raw_low_word"};
        if (bad != "")
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("frame %0d mismatch in%s", results_seen, bad);
                $display("  exp: failed=%b code=%h serial=%h button=%h status=%b bits=%0d raw=%h",
                         exp.frame_failed, exp.rolling_code, exp.serial_number, exp.button_id,
                         exp.frame_status, exp.bits_received, exp.raw_low_word);
                $display("  act: failed=%b code=%h serial=%h button=%h status=%b bits=%0d raw=%h",
                         got.frame_failed, got.rolling_code, got.serial_number, got.button_id,
                         got.frame_status, got.bits_received, got.raw_low_word);
            end
        end
    endfunction
endclass

module pwm_pulse_pair_frame_decoder_test;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DATA_ITEMS    = 900;
    localparam int TAIL_ITEMS    = 720;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit                     idle_on = 1'b0;
    int unsigned            cycles = 0;
    int                     data_items = 0;
    frame_scoreboard        sb;

    pwm_ppfd_in_if #(.TIME_WIDTH(16)) in_ch ();
    pwm_ppfd_out_if                   out_ch ();

    pwm_pulse_pair_frame_decoder #(
        .TIME_WIDTH (16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.frame_failed, out_ch.rolling_code, out_ch.serial_number,
                             out_ch.button_id, out_ch.frame_status, out_ch.bits_received,
                             out_ch.raw_low_word});
    end

    // result-side stalls
    initial
    begin
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_beat(logic [15:0] t, logic is_last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.pulse_time <= t;
        in_ch.last_pulse <= is_last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_beat(t, is_last);
    endtask

    // drain results, then cover a beat still in the decode stage
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] s, logic [15:0] l, logic [6:0] tol,
                              logic [7:0] pre, logic [6:0] tgt);
        logic [CFG_INDEX_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0]  val [6];
        idx[0] = REG_SHORT_TIME;
        idx[1] = REG_LONG_TIME;
        idx[2] = REG_TOLERANCE_PCT;
        idx[3] = REG_PREAMBLE_PULSES;
        idx[4] = REG_BIT_TARGET;
        idx[5] = REG_BIT_TARGET + 3'($urandom_range(1, 3));
        val[0] = s;
        val[1] = l;
        val[2] = {9'($urandom), tol};
        val[3] = {8'($urandom), pre};
        val[4] = {9'($urandom), tgt};
        val[5] = 16'($urandom);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // duration around a nominal time, mostly inside the window, sometimes on its edge
    function automatic logic [15:0] near_pulse(logic [15:0] nominal);
        int unsigned n;
        int unsigned window;
        int unsigned off;
        longint      v;
        n      = 32'(nominal);
        window = n * sb.tol_pct / PCT_SCALE;
        case ($urandom_range(0, 9))
            0:       off = window;
            1:       off = (window == 0) ? 0 : window - 1;
            default: off = (window == 0) ? 0 : $urandom_range(window - 1, 0);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = longint'(n) + longint'(off);
        else
            v = longint'(n) - longint'(off);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    initial
    begin
        logic [15:0] s, l, hi, lo;
        logic [6:0]  tol, tgt;
        logic [7:0]  pre;
        logic [15:0] pulses[$];
        int          npre, npairs, nframes;
        bit          capture_open, open_frame, data_bit;

        capture_open      = 1'b0;
        sb                = new();
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.pulse_time <= '0;
        in_ch.last_pulse <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: lone final high pulse, then two decoded bits, short of the target
        send_beat(16'd400, 1'b1);
        send_beat(16'd400, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd400, 1'b1);
        settle();

        set_config(16'd400, 16'd800, 7'd25, 8'd2, 7'd2);
        // capture ends inside the preamble
        send_beat(16'd0, 1'b0);
        send_beat(16'hFFFF, 1'b1);
        // target reached, extra pair ignored, unpaired final pulse
        send_beat(16'h1234, 1'b0);
        send_beat(16'd1, 1'b0);
        send_beat(16'd400, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd400, 1'b0);
        send_beat(16'd400, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd999, 1'b1);
        // bad pair stops decoding
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'd400, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd800, 1'b0);
        send_beat(16'd400, 1'b1);
        settle();

        // zero target, tolerance above 100, extreme nominal times
        set_config(16'd0, 16'hFFFF, 7'd127, 8'd0, 7'd0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd0, 1'b1);

        while (data_items < DATA_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       s = 16'd0;
                1:       s = 16'hFFFF;
                2:       s = 16'($urandom);
                default: s = 16'($urandom_range(100, 3000));
            endcase
            case ($urandom_range(0, 9))
                0:       l = 16'd0;
                1:       l = 16'hFFFF;
                2:       l = 16'($urandom);
                default: l = 16'(s * $urandom_range(2, 3));
            endcase
            case ($urandom_range(0, 9))
                0:       tol = 7'd0;
                1:       tol = 7'd127;
                2:       tol = 7'($urandom_range(100, 126));
                default: tol = 7'($urandom_range(10, 50));
            endcase
            case ($urandom_range(0, 9))
                0:       pre = 8'd255;
                1:       pre = 8'($urandom);
                2, 3:    pre = 8'd0;
                default: pre = 8'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 11))
                0:       tgt = 7'd0;
                1:       tgt = 7'd66;
                2:       tgt = 7'd127;
                3:       tgt = 7'($urandom_range(67, 126));
                default: tgt = 7'($urandom_range(1, 16));
            endcase
            set_config(s, l, tol, pre, tgt);
            idle_on = data_items < TAIL_ITEMS && $urandom_range(0, 3) != 0;
            nframes = (pre > 100 || tgt > 66) ? 1 : $urandom_range(1, 4);

            for (int f = 0; f < nframes; f++)
            begin
                if (data_items >= TAIL_ITEMS)
                    idle_on = 1'b0;
                pulses.delete();
                npre = int'(sb.preamble);
                if ($urandom_range(0, 9) == 0)
                    npre = npre + int'($urandom_range(0, 2)) - 1;
                for (int k = 0; k < npre; k++)
                    pulses.push_back(16'($urandom));
                if ($urandom_range(0, 7) == 0)
                    npairs = $urandom_range(0, sb.bit_target);
                else
                    npairs = sb.bit_target + $urandom_range(0, 2);
                for (int k = 0; k < npairs; k++)
                begin
                    if ($urandom_range(0, 39) == 0)
                    begin
                        hi = 16'($urandom);
                        lo = 16'($urandom);
                    end
                    else
                    begin
                        data_bit = 1'($urandom_range(0, 1));
                        hi = near_pulse(data_bit ? sb.long_time : sb.short_time);
                        lo = near_pulse(data_bit ? sb.short_time : sb.long_time);
                    end
                    pulses.push_back(hi);
                    pulses.push_back(lo);
                end
                if ($urandom_range(0, 3) == 0 || pulses.size() == 0)
                    pulses.push_back(16'($urandom));
                // now and then leave the capture open across a register change
                open_frame = data_items < TAIL_ITEMS && $urandom_range(0, 9) == 0;
                data_items += pulses.size() - ((npre > 0) ? npre : 0);
                for (int k = 0; k < pulses.size(); k++)
                    send_beat(pulses[k], !open_frame && k == pulses.size() - 1);
                capture_open = open_frame;
            end
        end
        idle_on = 1'b0;
        if (capture_open)
            send_beat(16'($urandom), 1'b1);
        settle();

        if (sb.failures == 0 && sb.expected_frames.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/pwm_ppfd_pkg.sv
src/pwm_ppfd_in_if.sv
src/pwm_ppfd_out_if.sv
src/pwm_ppfd_cfg.sv
src/pwm_ppfd_decode.sv
src/pwm_pulse_pair_frame_decoder.sv
test/pwm_pulse_pair_frame_decoder_test.sv
